FILE: hw/rtl/buddy_pkg.sv
package buddy_pkg;

  // pool geometry
  localparam int LEVELS     = 8;
  localparam int LEAF_BYTES = 64;

  localparam int LV_W  = $clog2(LEVELS);
  localparam int IDX_W = LEVELS - 1;
  localparam int ROW_W = 1 << (LEVELS - 1);
  localparam int BLK_W = $clog2(LEAF_BYTES) + LEVELS;
  localparam int REQ_W = 16;
  localparam int OFF_W = 13;
  localparam int CMP_W = (BLK_W > REQ_W) ? BLK_W : REQ_W;

  // leaf index of an offset by reciprocal multiply, exact over the offset field
  localparam int RCP_SH = OFF_W + $clog2(LEAF_BYTES);
  localparam int RCP_W  = OFF_W + 1;
  localparam int PROD_W = OFF_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_M = RCP_W'(((longint'(1) << RCP_SH)
                                               + longint'(LEAF_BYTES) - longint'(1))
                                              / longint'(LEAF_BYTES));

  localparam logic [CMP_W-1:0] LEAF_SZ = CMP_W'(LEAF_BYTES);
  localparam logic [CMP_W-1:0] POOL_SZ = CMP_W'(LEAF_BYTES) << (LEVELS - 1);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIZE,
    ST_SEARCH,
    ST_SPLIT,
    ST_FDIV,
    ST_FLEVEL,
    ST_FCHECK,
    ST_MERGE
  } state_t;

endpackage

FILE: hw/rtl/buddy_allocator.sv
// Binary buddy allocator over a pool of LEAF_BYTES << (LEVELS-1) bytes.
// Command port: a transaction is taken when start is high and busy is low;
// in_func selects allocate or free, in_request_size is the size wanted and
// in_free_offset the block to give back. busy stays high until the answer
// is ready. Every command gives exactly one result: out_valid pulses for one
// cycle with out_block_offset and out_status, and the receiver cannot stall
// it; the next command may be started in that same cycle.
// Allocate: the size is rounded through the shared compare unit, then the
// search climbs one tree level per cycle with a priority encoder and the
// split comes back down one level per cycle; the result follows in the next
// cycle. The walk is longest when a leaf is carved out of the whole pool.
// Free: the pool bound is checked and the leaf index taken by a constant
// reciprocal multiply, then the block level is found from the split bits,
// the free bit is checked and the merging follows. The tree walk goes one
// level per cycle through the row-wide bookkeeping.
// Synchronous reset leaves only the root free, no split and no pair bits,
// drops any command at work and returns no result for it.
module buddy_allocator
  import buddy_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_func,
  input  logic [REQ_W-1:0] in_request_size,
  input  logic [OFF_W-1:0] in_free_offset,
  output logic             out_valid,
  output logic [OFF_W-1:0] out_block_offset,
  output logic             out_status
);

  state_t state_r, state_nxt;

  // bookkeeping, one row per tree level
  logic [ROW_W-1:0] free_r  [LEVELS];
  logic [ROW_W-1:0] split_r [LEVELS];
  logic [ROW_W-1:0] pair_r  [LEVELS];

  logic [LV_W-1:0]  lv_r, lv_nxt;
  logic [LV_W-1:0]  want_r, want_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] q_r, q_nxt;
  logic [CMP_W-1:0] blk_r, blk_nxt;
  logic [CMP_W-1:0] rem_r, rem_nxt;
  logic [REQ_W-1:0] size_r, size_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0] out_off_r, out_off_nxt;
  logic             out_status_r, out_status_nxt;

  // shared compare unit
  logic [CMP_W-1:0] op_a, op_b;
  logic             op_ge;
  logic [PROD_W-1:0] rcp_prod;

  // bit writes into the level rows
  logic             fw_en, fw_val;
  logic [LV_W-1:0]  fw_row;
  logic [IDX_W-1:0] fw_col;
  logic             sw_en, sw_val;
  logic [LV_W-1:0]  sw_row;
  logic [IDX_W-1:0] sw_col;
  logic             pw_en, pw_val;
  logic [LV_W-1:0]  pw_row;
  logic [IDX_W-1:0] pw_col;

  logic [ROW_W-1:0] lvl_mask, srch_row;
  logic             srch_hit;
  logic [IDX_W-1:0] srch_idx;
  logic [IDX_W-1:0] q_sh, pcol;
  logic [IDX_W-1:0] off_sh;
  logic [BLK_W-1:0] off_prod;
  logic             last_lv, pair_new;

  assign op_a   = (state_r == ST_SIZE) ? blk_r : rem_r;
  assign op_b   = (state_r == ST_SIZE) ? CMP_W'(size_r) : blk_r;
  assign op_ge  = (op_a >= op_b);

  assign rcp_prod = PROD_W'(rem_r[OFF_W-1:0]) * PROD_W'(RCP_M);

  // lowest free node of the level in lv_r
  assign lvl_mask = ~({ROW_W{1'b1}} << (ROW_W'(1) << lv_r));
  assign srch_row = free_r[lv_r] & lvl_mask;

  always_comb begin
    srch_hit = 1'b0;
    srch_idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (srch_row[i]) begin
        srch_hit = 1'b1;
        srch_idx = IDX_W'(i);
      end
    end
  end

  assign q_sh     = q_r >> (LV_W'(LEVELS - 1) - lv_r);
  assign pcol     = (lv_r == '0) ? '0 : (idx_r >> 1);
  assign last_lv  = (lv_r == LV_W'(LEVELS - 1));
  assign pair_new = ~pair_r[lv_r][pcol];

  assign off_sh   = idx_r << (LV_W'(LEVELS - 1) - want_r);
  assign off_prod = BLK_W'(off_sh) * BLK_W'(LEAF_BYTES);

  always_comb begin
    state_nxt      = state_r;
    lv_nxt         = lv_r;
    want_nxt       = want_r;
    idx_nxt        = idx_r;
    q_nxt          = q_r;
    blk_nxt        = blk_r;
    rem_nxt        = rem_r;
    size_nxt       = size_r;
    out_valid_nxt  = 1'b0;
    out_off_nxt    = out_off_r;
    out_status_nxt = out_status_r;
    fw_en  = 1'b0;
    fw_val = 1'b0;
    fw_row = lv_r;
    fw_col = idx_r;
    sw_en  = 1'b0;
    sw_val = 1'b0;
    sw_row = lv_r;
    sw_col = idx_r;
    pw_en  = 1'b0;
    pw_val = pair_new;
    pw_row = lv_r;
    pw_col = pcol;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          size_nxt = in_request_size;
          rem_nxt  = CMP_W'(in_free_offset);
          q_nxt    = '0;
          lv_nxt   = LV_W'(LEVELS - 1);
          if (in_func == FUNC_ALLOC) begin
            blk_nxt   = LEAF_SZ;
            want_nxt  = LV_W'(LEVELS - 1);
            state_nxt = ST_SIZE;
          end else begin
            blk_nxt   = POOL_SZ;
            state_nxt = ST_FDIV;
          end
        end
      end

      ST_SIZE: begin
        if (op_ge) begin
          lv_nxt    = want_r;
          state_nxt = ST_SEARCH;
        end else if (want_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_off_nxt    = '0;
          out_status_nxt = STATUS_EXHAUSTED;
          state_nxt      = ST_IDLE;
        end else begin
          blk_nxt  = blk_r << 1;
          want_nxt = want_r - LV_W'(1);
        end
      end

      ST_SEARCH: begin
        if (srch_hit) begin
          fw_en     = 1'b1;
          fw_col    = srch_idx;
          idx_nxt   = srch_idx;
          state_nxt = ST_SPLIT;
        end else if (lv_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_off_nxt    = '0;
          out_status_nxt = STATUS_EXHAUSTED;
          state_nxt      = ST_IDLE;
        end else begin
          lv_nxt = lv_r - LV_W'(1);
        end
      end

      ST_SPLIT: begin
        pw_en = 1'b1;
        if (lv_r == want_r) begin
          out_valid_nxt  = 1'b1;
          out_off_nxt    = OFF_W'(off_prod);
          out_status_nxt = STATUS_OK;
          state_nxt      = ST_IDLE;
        end else begin
          // split: mark this node, free the right child, go left
          sw_en   = 1'b1;
          sw_val  = 1'b1;
          fw_en   = 1'b1;
          fw_val  = 1'b1;
          fw_row  = lv_r + LV_W'(1);
          fw_col  = IDX_W'({idx_r, 1'b1});
          idx_nxt = IDX_W'({idx_r, 1'b0});
          lv_nxt  = lv_r + LV_W'(1);
        end
      end

      ST_FDIV: begin
        // offsets past the pool are dropped, else take the leaf index
        if (op_ge) begin
          out_valid_nxt  = 1'b1;
          out_off_nxt    = '0;
          out_status_nxt = STATUS_OK;
          state_nxt      = ST_IDLE;
        end else begin
          q_nxt     = IDX_W'(rcp_prod >> RCP_SH);
          state_nxt = ST_FLEVEL;
        end
      end

      ST_FLEVEL: begin
        if (lv_r == '0 || split_r[lv_r - LV_W'(1)][q_sh >> 1]) begin
          state_nxt = ST_FCHECK;
        end else begin
          lv_nxt = lv_r - LV_W'(1);
        end
      end

      ST_FCHECK: begin
        idx_nxt = q_sh;
        if (free_r[lv_r][q_sh]) begin
          // double free
          out_valid_nxt  = 1'b1;
          out_off_nxt    = '0;
          out_status_nxt = STATUS_OK;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_MERGE;
        end
      end

      ST_MERGE: begin
        pw_en = 1'b1;
        sw_en = !last_lv;
        fw_en = 1'b1;
        if (!pair_new && lv_r != '0) begin
          // buddy is free too: take it out and climb
          fw_col  = idx_r ^ IDX_W'(1);
          idx_nxt = idx_r >> 1;
          lv_nxt  = lv_r - LV_W'(1);
        end else begin
          fw_val         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_off_nxt    = '0;
          out_status_nxt = STATUS_OK;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lv_r         <= lv_nxt;
    want_r       <= want_nxt;
    idx_r        <= idx_nxt;
    q_r          <= q_nxt;
    blk_r        <= blk_nxt;
    rem_r        <= rem_nxt;
    size_r       <= size_nxt;
    out_off_r    <= out_off_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) begin
        free_r[l]  <= '0;
        split_r[l] <= '0;
        pair_r[l]  <= '0;
      end
      free_r[0][0] <= 1'b1;
    end else begin
      if (fw_en) free_r[fw_row][fw_col] <= fw_val;
      if (sw_en) split_r[sw_row][sw_col] <= sw_val;
      if (pw_en) pair_r[pw_row][pw_col] <= pw_val;
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_block_offset = out_off_r;
  assign out_status       = out_status_r;

`ifndef ASSERT_OFF
  a_fail_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_EXHAUSTED |-> out_block_offset == '0)
    else $error("failed allocate returned a non-zero offset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("command taken but block not busy");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("command finished without a result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");
`endif

endmodule

FILE: dv/testbench.sv
module testbench
  import buddy_pkg::*;
();

  localparam int NODES    = (1 << LEVELS) - 1;
  localparam int HALF     = 1 << (LEVELS - 1);
  localparam int POOL     = LEAF_BYTES << (LEVELS - 1);
  localparam int RUN_LEN  = 800;
  localparam int WATCHDOG = 1000;
  localparam int SETTLE   = 3 * LEVELS + 10;

  typedef struct packed {
    logic             func;
    logic [REQ_W-1:0] size;
    logic [OFF_W-1:0] off;
  } command_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic             status;
  } answer_t;

  typedef struct packed {
    logic [OFF_W-1:0] base;
    logic [15:0]      bytes;
  } held_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             in_func = FUNC_ALLOC;
  logic [REQ_W-1:0] in_request_size = '0;
  logic [OFF_W-1:0] in_free_offset = '0;
  logic             out_valid;
  logic [OFF_W-1:0] out_block_offset;
  logic             out_status;

  command_t command_queue[$];
  answer_t  answers_due[$];
  held_t    live_blocks[$];

  // allocator bookkeeping as the block should keep it
  bit tree_free[NODES];
  bit pair_parity[HALF];
  bit tree_split[HALF];

  logic took = 1'b0;
  int   hold_off = 0;
  int   stalled = 0;
  int   errors = 0;
  bit   calm = 1'b0;

  buddy_allocator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_request_size  (in_request_size),
    .in_free_offset   (in_free_offset),
    .out_valid        (out_valid),
    .out_block_offset (out_block_offset),
    .out_status       (out_status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int node_at(int lv, int idx);
    return (1 << lv) - 1 + idx;
  endfunction

  function automatic longint blk_bytes(int lv);
    return longint'(LEAF_BYTES) << (LEVELS - 1 - lv);
  endfunction

  function automatic bit toggle_pair(int lv, int idx);
    int p;
    p = (lv == 0) ? 0 : ((1 << (lv - 1)) + (idx >> 1));
    p = p & (HALF - 1);
    pair_parity[p] = !pair_parity[p];
    return pair_parity[p];
  endfunction

  function automatic void unsplit(int lv, int idx);
    if (lv < LEVELS - 1) tree_split[node_at(lv, idx)] = 1'b0;
  endfunction

  function automatic void clear_tree();
    foreach (tree_free[i]) tree_free[i] = 1'b0;
    foreach (pair_parity[i]) pair_parity[i] = 1'b0;
    foreach (tree_split[i]) tree_split[i] = 1'b0;
    tree_free[0] = 1'b1;
  endfunction

  function automatic void predict_alloc(input logic [REQ_W-1:0] size,
                                        output answer_t ans, output int grant);
    longint blk;
    int     want;
    int     h;
    int     idx;
    int     lv;
    bit     found;
    blk = LEAF_BYTES;
    want = LEVELS - 1;
    idx = 0;
    found = 1'b0;
    grant = 0;
    ans.offset = '0;
    ans.status = STATUS_EXHAUSTED;
    while (blk < size && want > 0) begin
      blk = blk << 1;
      want--;
    end
    if (blk < size) return;
    // lowest free node, wanted level first, then upward
    for (h = want; h >= 0 && !found; h--) begin
      for (int i = 0; i < (1 << h); i++) begin
        if (!found && tree_free[node_at(h, i)]) begin
          idx = i;
          found = 1'b1;
        end
      end
    end
    if (!found) return;
    lv = h + 1;
    tree_free[node_at(lv, idx)] = 1'b0;
    void'(toggle_pair(lv, idx));
    while (lv != want) begin
      tree_split[node_at(lv, idx)] = 1'b1;
      idx = idx << 1;
      lv++;
      tree_free[node_at(lv, idx + 1)] = 1'b1;
      void'(toggle_pair(lv, idx));
    end
    ans.offset = OFF_W'(longint'(idx) * blk_bytes(want));
    ans.status = STATUS_OK;
    grant = int'(blk);
  endfunction

  function automatic void predict_free(input logic [OFF_W-1:0] off);
    int lv;
    int idx;
    bit diff;
    bit merged;
    if (longint'(off) >= blk_bytes(0)) return;
    for (lv = LEVELS - 1; lv > 0; lv--) begin
      if (tree_split[node_at(lv - 1, int'(longint'(off) / blk_bytes(lv - 1)))]) break;
    end
    idx = int'(longint'(off) / blk_bytes(lv));
    if (tree_free[node_at(lv, idx)]) return;
    merged = 1'b0;
    while (!merged) begin
      diff = toggle_pair(lv, idx);
      if (!diff && lv != 0) begin
        tree_free[node_at(lv, idx ^ 1)] = 1'b0;
        unsplit(lv, idx);
        lv--;
        idx = idx >> 1;
      end else begin
        tree_free[node_at(lv, idx)] = 1'b1;
        unsplit(lv, idx);
        merged = 1'b1;
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 100) $display("mismatch at %0t: %s", $time, what);
  endtask

  // driver: fields change on the falling edge
  always @(negedge clk) begin : feed
    command_t cmd;
    if (rst_n && (!start || took)) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        start <= 1'b0;
      end else if (command_queue.size() != 0) begin
        cmd = command_queue.pop_front();
        in_func <= cmd.func;
        in_request_size <= cmd.size;
        in_free_offset <= cmd.off;
        start <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) hold_off <= $urandom_range(1, 19);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: transactions on both sides are taken at the rising edge
  always @(posedge clk) begin : watch
    answer_t seen;
    answer_t due;
    answer_t fresh;
    int      grant;
    held_t   blk;
    if (!rst_n) begin
      took <= 1'b0;
      stalled <= 0;
      clear_tree();
    end else begin
      took <= start && !busy;
      if (out_valid) begin
        seen.offset = out_block_offset;
        seen.status = out_status;
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("result offset %0d status %0d with no command outstanding",
                                    seen.offset, seen.status));
        end else begin
          due = answers_due.pop_front();
          if (seen.offset !== due.offset)
            report_mismatch($sformatf("block_offset %0d, expected %0d",
                                      seen.offset, due.offset));
          if (seen.status !== due.status)
            report_mismatch($sformatf("status %0d, expected %0d", seen.status, due.status));
        end
      end
      if (start && !busy) begin
        if (in_func == FUNC_ALLOC) begin
          predict_alloc(in_request_size, fresh, grant);
          if (fresh.status == STATUS_OK) begin
            blk.base = fresh.offset;
            blk.bytes = 16'(grant);
            live_blocks.push_back(blk);
          end
        end else begin
          predict_free(in_free_offset);
          fresh.offset = '0;
          fresh.status = STATUS_OK;
        end
        answers_due.push_back(fresh);
      end
      stalled <= (out_valid || (start && !busy)) ? 0 : stalled + 1;
    end
  end

  always @(posedge clk) begin
    if (stalled >= WATCHDOG) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic queue_command(input logic func, input logic [REQ_W-1:0] size,
                               input logic [OFF_W-1:0] off);
    command_t cmd;
    while (command_queue.size() >= 2) @(posedge clk);
    cmd.func = func;
    cmd.size = size;
    cmd.off = off;
    command_queue.push_back(cmd);
  endtask

  task automatic wait_drained();
    while (command_queue.size() != 0 || start || answers_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [REQ_W-1:0] pick_size();
    int k;
    int bytes;
    k = ($urandom_range(0, 3) == 0) ? $urandom_range(4, LEVELS - 1) : $urandom_range(0, 3);
    bytes = LEAF_BYTES << k;
    if (k == 0) return REQ_W'($urandom_range(0, bytes));
    return REQ_W'($urandom_range(bytes / 2 + 1, bytes));
  endfunction

  initial begin : stimulus
    int               made;
    int               j;
    int               alloc_pct;
    held_t            blk;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] last_freed;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // too large, whole pool, exhausted, misaligned and double free
    queue_command(FUNC_ALLOC, 16'hFFFF, 13'h1FFF);
    queue_command(FUNC_ALLOC, REQ_W'(POOL + 1), '0);
    queue_command(FUNC_ALLOC, REQ_W'(POOL), '0);
    queue_command(FUNC_ALLOC, 16'd1, '0);
    queue_command(FUNC_FREE, 16'hFFFF, 13'd100);
    queue_command(FUNC_FREE, '0, 13'd0);
    // zero and leaf-edge sizes split all the way down, then half-pool sizes and frees
    queue_command(FUNC_ALLOC, 16'd0, '0);
    queue_command(FUNC_ALLOC, REQ_W'(LEAF_BYTES), '0);
    queue_command(FUNC_ALLOC, REQ_W'(LEAF_BYTES + 1), '0);
    queue_command(FUNC_ALLOC, REQ_W'(POOL / 2), '0);
    queue_command(FUNC_ALLOC, REQ_W'(POOL / 2 + 1), '0);
    queue_command(FUNC_FREE, '0, OFF_W'(LEAF_BYTES + 10));
    queue_command(FUNC_FREE, '0, OFF_W'(LEAF_BYTES));
    queue_command(FUNC_FREE, '0, 13'd0);
    queue_command(FUNC_FREE, '0, OFF_W'(2 * LEAF_BYTES));
    queue_command(FUNC_FREE, '0, OFF_W'(POOL / 2 + POOL / 2 - 1));
    // never allocated space while one leaf is held
    queue_command(FUNC_ALLOC, 16'd3, '0);
    queue_command(FUNC_FREE, '0, 13'd4000);
    queue_command(FUNC_FREE, '0, 13'd0);
    wait_drained();
    live_blocks.delete();

    made = 0;
    last_freed = '0;
    while (made < RUN_LEN) begin
      if (made > RUN_LEN * 7 / 8) calm = 1'b1;
      // alternate filling and draining phases so the pool runs full and merges back
      alloc_pct = ((made / 60) % 2 == 0) ? 75 : 30;
      if ($urandom_range(0, 99) < 6) begin
        case ($urandom_range(0, 2))
          0: queue_command(FUNC_FREE, REQ_W'($urandom), OFF_W'($urandom));
          1: queue_command(FUNC_FREE, REQ_W'($urandom), last_freed);
          default: queue_command(FUNC_ALLOC, REQ_W'($urandom_range(POOL + 1, 65535)),
                                 OFF_W'($urandom));
        endcase
      end else if (live_blocks.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
        queue_command(FUNC_ALLOC, pick_size(), OFF_W'($urandom));
        made++;
      end else begin
        j = $urandom_range(0, live_blocks.size() - 1);
        blk = live_blocks[j];
        live_blocks.delete(j);
        off = blk.base;
        if ($urandom_range(0, 2) == 0) off = off + OFF_W'($urandom_range(0, blk.bytes - 1));
        last_freed = off;
        queue_command(FUNC_FREE, REQ_W'($urandom), off);
        made++;
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
